>>> sv/skinmb_pkg.sv
// Shared types, constants and rounding helper for the skinning matrix blend block.
`timescale 1ns / 1ps

package skinmb_pkg;

  localparam int MaxJoints   = 64;
  localparam int MaxVertices = 256;

  localparam int JointW  = $clog2(MaxJoints);
  localparam int VertW   = $clog2(MaxVertices);
  localparam int JcntW   = 7;
  localparam int VcntW   = 9;
  localparam int ElemW   = 4;
  localparam int ValW    = 32;
  localparam int WeightW = 17;
  localparam int PsumW   = 66;
  localparam int AccW    = 64;

  localparam logic [ElemW-1:0] LastElem = 4'd15;
  localparam logic [WeightW-1:0] WeightOne = 17'd65536;

  typedef enum logic [1:0] {
    OpWeight = 2'd0,
    OpBind   = 2'd1,
    OpWorld  = 2'd2,
    OpQuery  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RegJointCount  = 2'd0,
    RegVertexCount = 2'd1
  } reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              wr_weight;
    logic              wr_bind;
    logic              wr_world;
    logic              issue;
    logic [VertW-1:0]  vertex;
    logic [JointW-1:0] joint;
    logic [ElemW-1:0]  elem;
    logic [1:0]        k;
    logic              first_k;
    logic              last_k;
    logic              first_j;
    logic              last_j;
    logic              load_err;
    logic              load_zero;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_taken;
  } st_t;

  // Round a Q.16 fraction to an integer LSB, ties toward plus infinity,
  // and saturate to 32 bits signed.
  function automatic logic signed [ValW-1:0] rnd_sat(input logic signed [PsumW-1:0] x);
    logic signed [PsumW-1:0] t;
    logic signed [PsumW-1:0] s;
    begin
      t = x + PsumW'(32768);
      s = t >>> 16;
      if (s > PsumW'(64'sh7FFF_FFFF)) begin
        rnd_sat = 32'sh7FFF_FFFF;
      end else if (s < -PsumW'(64'sh8000_0000)) begin
        rnd_sat = 32'sh8000_0000;
      end else begin
        rnd_sat = s[ValW-1:0];
      end
    end
  endfunction

endpackage

>>> sv/skin_matrix_blend.sv
// Top level of the linear blend skinning matrix block.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | op, vertex, joint, element, value
//  out     | output    | out_valid_o/out_ready_i| out_element, out_value, status, last
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index, cfg_data
//
// A good query gives 16 results, computed by the single multiply-accumulate
// pipe that reads one bind and one world element per cycle while the sequencer
// runs. An out-of-range query gives one error result. Reset clears control and
// configuration; memories are not cleared. A stalled output holds the sequencer
// before the next element.
`timescale 1ns / 1ps

module skin_matrix_blend import skinmb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             op_i,
  input  logic [VertW-1:0]       vertex_i,
  input  logic [JointW-1:0]      joint_i,
  input  logic [ElemW-1:0]       element_i,
  input  logic signed [ValW-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ElemW-1:0]       out_element_o,
  output logic signed [ValW-1:0] out_value_o,
  output logic                   status_o,
  output logic                   last_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i
);

  cmd_t cmd;
  st_t  st;

  // Controller.
  skinmb_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .vertex_i, .joint_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .st_i(st), .cmd_o(cmd)
  );

  // Datapath.
  skinmb_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_element_i(element_i), .in_value_i(value_i),
    .st_o(st), .out_valid_o, .out_ready_i, .out_element_o, .out_value_o,
    .status_o, .last_o
  );

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> in_ready_o)
    else $error("block not free after the final result");
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (last_o && out_value_o == 0 && out_element_o == 0))
    else $error("malformed error result");

endmodule

>>> sv/skinmb_ctrl.sv
// Controller: handshakes, configuration registers and the element/joint/k sequencer.
`timescale 1ns / 1ps

module skinmb_ctrl import skinmb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [VertW-1:0]  vertex_i,
  input  logic [JointW-1:0] joint_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  st_t               st_i,
  output cmd_t              cmd_o
);

  typedef enum logic [1:0] {
    Idle,
    Run,
    Drain
  } state_e;

  state_e            state_q;
  logic [JcntW-1:0]  jcnt_q;
  logic [VcntW-1:0]  vcnt_q;
  logic [VertW-1:0]  vert_q;
  logic [JcntW-1:0]  nj_q;
  logic [ElemW-1:0]  elem_q;
  logic [JointW-1:0] j_q;
  logic [1:0]        k_q;
  logic              in_acc;
  logic [JcntW-1:0]  nj_d;
  logic              last_j;

  assign in_ready_o  = (state_q == Idle);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign nj_d        = (jcnt_q > JcntW'(MaxJoints)) ? JcntW'(MaxJoints) : jcnt_q;
  assign last_j      = ({1'b0, j_q} == nj_q - JcntW'(1));

  // Command decode.
  always_comb begin
    cmd_o           = '0;
    cmd_o.wr_weight = in_acc && (op_i == OpWeight);
    cmd_o.wr_bind   = in_acc && (op_i == OpBind);
    cmd_o.wr_world  = in_acc && (op_i == OpWorld);
    cmd_o.load_err  = in_acc && (op_i == OpQuery) && ({1'b0, vertex_i} >= vcnt_q);
    cmd_o.vertex    = in_ready_o ? vertex_i : vert_q;
    cmd_o.joint     = in_ready_o ? joint_i : j_q;
    cmd_o.elem      = elem_q;
    cmd_o.k         = k_q;
    cmd_o.first_k   = (k_q == 2'd0);
    cmd_o.last_k    = (k_q == 2'd3);
    cmd_o.first_j   = (j_q == '0);
    cmd_o.last_j    = last_j;
    cmd_o.issue     = (state_q == Run) && (nj_q != '0);
    cmd_o.load_zero = (state_q == Run) && (nj_q == '0);
  end

  // State, configuration and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      jcnt_q  <= JcntW'(1);
      vcnt_q  <= '0;
      vert_q  <= '0;
      nj_q    <= '0;
      elem_q  <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegJointCount:  jcnt_q <= cfg_data_i[JcntW-1:0];
          RegVertexCount: vcnt_q <= cfg_data_i[VcntW-1:0];
          default: ;
        endcase
      end
      case (state_q)
        Idle: begin
          if (in_acc && (op_i == OpQuery)) begin
            vert_q <= vertex_i;
            nj_q   <= nj_d;
            elem_q <= '0;
            j_q    <= '0;
            k_q    <= '0;
            state_q <= cmd_o.load_err ? Drain : Run;
            if (cmd_o.load_err) begin
              elem_q <= LastElem;
            end
          end
        end
        Run: begin
          if (nj_q == '0) begin
            state_q <= Drain;
          end else begin
            k_q <= k_q + 2'd1;
            if (k_q == 2'd3) begin
              if (last_j) begin
                j_q     <= '0;
                state_q <= Drain;
              end else begin
                j_q <= j_q + JointW'(1);
              end
            end
          end
        end
        Drain: begin
          if (st_i.out_taken) begin
            if (elem_q == LastElem) begin
              state_q <= Idle;
            end else begin
              elem_q  <= elem_q + ElemW'(1);
              state_q <= Run;
            end
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end

  // A query sequence only ever runs with a latched vertex that passed the range check.
  a_run_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Run) |-> ({1'b0, vert_q} < vcnt_q || $past(cfg_valid_i)))
    else $error("query sequence running on an out-of-range vertex");
  a_k_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.issue && cmd_o.last_k && cmd_o.last_j) |=> (state_q == Drain))
    else $error("sequencer did not stop after the last joint");
  a_no_issue_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd_o.issue && !cmd_o.load_zero)
    else $error("datapath issue while accepting items");

endmodule

>>> sv/skinmb_dp.sv
// Datapath: weight and matrix memories, MAC pipeline and the output register.
`timescale 1ns / 1ps

module skinmb_dp import skinmb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  input  logic [ElemW-1:0]       in_element_i,
  input  logic signed [ValW-1:0] in_value_i,
  output st_t                    st_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ElemW-1:0]       out_element_o,
  output logic signed [ValW-1:0] out_value_o,
  output logic                   status_o,
  output logic                   last_o
);

  localparam int WAddrW = VertW + JointW;
  localparam int MAddrW = JointW + ElemW;

  logic [WeightW-1:0]    weight_mem [MaxVertices*MaxJoints];
  logic signed [ValW-1:0] bind_mem  [MaxJoints*16];
  logic signed [ValW-1:0] world_mem [MaxJoints*16];

  logic [WAddrW-1:0] waddr;
  logic [MAddrW-1:0] baddr_wr;
  logic [MAddrW-1:0] baddr_rd;
  logic [MAddrW-1:0] waddr_rd;
  logic [WeightW-1:0] wclamp;

  // Stage tags.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, fin_q;
  logic fk1_q, lk1_q, fj1_q, lj1_q;
  logic fk2_q, lk2_q, fj2_q, lj2_q;
  logic fj3_q, lj3_q, lk3_q, fj4_q, lj4_q, fj5_q, lj5_q;
  logic [ElemW-1:0] e1_q, e2_q, e3_q, e4_q, e5_q, e6_q;

  logic signed [ValW-1:0]    bd_q, wd_q, pe_q;
  logic [WeightW-1:0]        wt1_q, wt2_q, wt3_q, wt4_q;
  logic signed [2*ValW-1:0]  prod_q;
  logic signed [PsumW-1:0]   psum_q;
  logic signed [ValW+WeightW:0] wp_q;
  logic signed [AccW-1:0]    acc_q;
  logic                      out_valid_q;
  logic [ElemW-1:0]          out_elem_q;
  logic signed [ValW-1:0]    out_val_q;
  logic                      out_stat_q;
  logic                      out_last_q;

  assign waddr    = {cmd_i.vertex, cmd_i.joint};
  assign baddr_wr = {cmd_i.joint, in_element_i};
  assign baddr_rd = {cmd_i.joint, cmd_i.elem[3:2], cmd_i.k};
  assign waddr_rd = {cmd_i.joint, cmd_i.k, cmd_i.elem[1:0]};

  // Weight clamp to 0..one.
  always_comb begin
    if (in_value_i < 0) begin
      wclamp = '0;
    end else if (in_value_i > $signed({15'd0, WeightOne})) begin
      wclamp = WeightOne;
    end else begin
      wclamp = in_value_i[WeightW-1:0];
    end
  end

  // Memories, up to one write and one read per cycle each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_weight) begin
      weight_mem[waddr] <= wclamp;
    end
    wt1_q <= weight_mem[waddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_bind) begin
      bind_mem[baddr_wr] <= in_value_i;
    end
    bd_q <= bind_mem[baddr_rd];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_world) begin
      world_mem[baddr_wr] <= in_value_i;
    end
    wd_q <= world_mem[waddr_rd];
  end

  // Pipeline valid tags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0; fin_q <= 1'b0;
    end else begin
      v1_q  <= cmd_i.issue;
      v2_q  <= v1_q;
      v3_q  <= v2_q && lk2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      fin_q <= v5_q && lj5_q;
    end
  end

  // Product, partial sum, weighting and accumulation.
  always_ff @(posedge clk_i) begin
    fk1_q <= cmd_i.first_k; lk1_q <= cmd_i.last_k;
    fj1_q <= cmd_i.first_j; lj1_q <= cmd_i.last_j; e1_q <= cmd_i.elem;
    fk2_q <= fk1_q; lk2_q <= lk1_q; fj2_q <= fj1_q; lj2_q <= lj1_q; e2_q <= e1_q;
    wt2_q <= wt1_q;
    prod_q <= bd_q * wd_q;
    if (v2_q) begin
      psum_q <= fk2_q ? PsumW'(prod_q) : psum_q + PsumW'(prod_q);
    end
    fj3_q <= fj2_q; lj3_q <= lj2_q; lk3_q <= lk2_q; e3_q <= e2_q; wt3_q <= wt2_q;
    pe_q  <= rnd_sat(psum_q);
    fj4_q <= fj3_q; lj4_q <= lj3_q; e4_q <= e3_q; wt4_q <= wt3_q;
    wp_q  <= pe_q * $signed({1'b0, wt4_q});
    fj5_q <= fj4_q; lj5_q <= lj4_q; e5_q <= e4_q;
    if (v5_q) begin
      acc_q <= fj5_q ? AccW'(wp_q) : acc_q + AccW'(wp_q);
    end
    e6_q <= e5_q;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_q || cmd_i.load_err || cmd_i.load_zero) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_err) begin
      out_elem_q <= '0;
      out_val_q  <= '0;
      out_stat_q <= 1'b1;
      out_last_q <= 1'b1;
    end else if (cmd_i.load_zero) begin
      out_elem_q <= cmd_i.elem;
      out_val_q  <= '0;
      out_stat_q <= 1'b0;
      out_last_q <= (cmd_i.elem == LastElem);
    end else if (fin_q) begin
      out_elem_q <= e6_q;
      out_val_q  <= rnd_sat(PsumW'(acc_q));
      out_stat_q <= 1'b0;
      out_last_q <= (e6_q == LastElem);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_element_o   = out_elem_q;
  assign out_value_o     = out_val_q;
  assign status_o        = out_stat_q;
  assign last_o          = out_last_q;
  assign st_o.out_taken  = out_valid_q && out_ready_i;

  // Only the last k of a product sends a value down to the weighting stage.
  a_fin_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !out_valid_q || out_ready_i)
    else $error("blended element overwrites a pending result");
  a_load_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fin_q && (cmd_i.load_err || cmd_i.load_zero)))
    else $error("two result sources in one cycle");
  a_v3_lastk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> lk3_q)
    else $error("partial product left the sum stage early");

endmodule
